### sv/impc_pkg.sv
`default_nettype none

package impc_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int THRESH_W   = 13;
  localparam int ONE_G_W    = 12;
  localparam int BASE_W     = 13;
  localparam int TICKS_W    = 16;
  localparam int TYPE_W     = 4;
  localparam int SEV_W      = 2;
  localparam int REQ_W      = 2;

  // Scaled baselines are five times a 13-bit level.
  localparam int BASE5_W = BASE_W + 3;
  localparam int MULTI_IMPACT_LIMIT = 5;

  localparam logic [THRESH_W-1:0] SEV_THR_RST    = THRESH_W'(2564);
  localparam logic [THRESH_W-1:0] MOD_THR_RST    = THRESH_W'(1282);
  localparam logic [ONE_G_W-1:0]  ONE_G_RST      = ONE_G_W'(256);
  localparam logic [BASE_W-1:0]   BASE_RST       = '0;
  localparam logic [TICKS_W-1:0]  WARN_TICKS_RST = TICKS_W'(10000);
  localparam logic [TICKS_W-1:0]  HOLD_TICKS_RST = TICKS_W'(10000);

  typedef enum logic [REQ_W-1:0] {
    REQ_SAMPLE = 2'd0,
    REQ_TICK   = 2'd1,
    REQ_BUTTON = 2'd2
  } req_t;

  typedef enum logic [SEV_W-1:0] {
    SEV_NONE  = 2'd0,
    SEV_MINOR = 2'd1,
    SEV_MAJOR = 2'd2
  } sev_t;

  typedef enum logic [TYPE_W-1:0] {
    IMP_NONE     = 4'd0,
    IMP_FALL     = 4'd1,
    IMP_COLLAPSE = 4'd2,
    IMP_LANDING  = 4'd3,
    IMP_FRONT    = 4'd4,
    IMP_REAR     = 4'd5,
    IMP_RIGHT    = 4'd6,
    IMP_LEFT     = 4'd7,
    IMP_BLUNT    = 4'd8
  } itype_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SEV_THR    = 3'd0,
    CFG_MOD_THR    = 3'd1,
    CFG_ONE_G      = 3'd2,
    CFG_BASE_X     = 3'd3,
    CFG_BASE_Y     = 3'd4,
    CFG_BASE_Z     = 3'd5,
    CFG_WARN_TICKS = 3'd6,
    CFG_HOLD_TICKS = 3'd7
  } cfg_reg_t;

endpackage

`default_nettype wire

### sv/impact_classifier.sv
// Channel  Handshake              Payload
// in       in_valid / in_ready    req_type, accel_x/y/z, button_low
// out      out_valid / out_ready  hit_kind, severity, flags, impact_total
// cfg      cfg_valid / cfg_ready  cfg_index, cfg_wdata (cfg_ready is always high)
//
// One beat is accepted per cycle except while a stall holds in_ready low.
// The stages are input register, axis squares, magnitude and type, result register.
// The three axis squarers have a stage of their own.
// Reset is synchronous and active low; it restores the register defaults.
// Each stage holds while the stage after it is full and stalled, so empty stages keep filling.
`default_nettype none

module impact_classifier #(
  parameter int ACCEL_WIDTH = 13,
  parameter int COUNT_WIDTH = 8,
  parameter int TIMER_WIDTH = 16
) (
  input  wire                             clk,
  input  wire                             rst_n,
  input  wire                             in_valid,
  output logic                            in_ready,
  input  wire  [impc_pkg::REQ_W-1:0]      in_req_type,
  input  wire  signed [ACCEL_WIDTH-1:0]   in_accel_x,
  input  wire  signed [ACCEL_WIDTH-1:0]   in_accel_y,
  input  wire  signed [ACCEL_WIDTH-1:0]   in_accel_z,
  input  wire                             in_button_low,
  output logic                            out_valid,
  input  wire                             out_ready,
  output logic [impc_pkg::TYPE_W-1:0]     out_hit_kind,
  output logic [impc_pkg::SEV_W-1:0]      out_severity,
  output logic                            out_major_started,
  output logic                            out_warning_led_on,
  output logic                            out_blink_on,
  output logic                            out_doctor_led_on,
  output logic                            out_cancelled,
  output logic                            out_cleared,
  output logic [COUNT_WIDTH-1:0]          out_impact_total,
  input  wire                             cfg_valid,
  output logic                            cfg_ready,
  input  wire  [impc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire  [impc_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import impc_pkg::*;

  localparam int DW   = ((ACCEL_WIDTH > 13) ? ACCEL_WIDTH : 13) + 1;
  localparam int SQW  = 2 * DW;
  localparam int M2W  = SQW + 2;
  localparam int CW   = (DW > BASE5_W) ? DW : BASE5_W;
  localparam int TSQW = 2 * THRESH_W;

  // Configuration registers.
  logic [THRESH_W-1:0] sev_thr_r, mod_thr_r;
  logic [ONE_G_W-1:0]  one_g_r;
  logic [BASE_W-1:0]   base_x_r, base_y_r, base_z_r;
  logic [TICKS_W-1:0]  warn_ticks_r, hold_ticks_r;
  logic [TSQW-1:0]     sev_sq_r, mod_sq_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sev_thr_r    <= SEV_THR_RST;
      mod_thr_r    <= MOD_THR_RST;
      one_g_r      <= ONE_G_RST;
      base_x_r     <= BASE_RST;
      base_y_r     <= BASE_RST;
      base_z_r     <= BASE_RST;
      warn_ticks_r <= WARN_TICKS_RST;
      hold_ticks_r <= HOLD_TICKS_RST;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_SEV_THR:    sev_thr_r    <= cfg_wdata[THRESH_W-1:0];
        CFG_MOD_THR:    mod_thr_r    <= cfg_wdata[THRESH_W-1:0];
        CFG_ONE_G:      one_g_r      <= cfg_wdata[ONE_G_W-1:0];
        CFG_BASE_X:     base_x_r     <= cfg_wdata[BASE_W-1:0];
        CFG_BASE_Y:     base_y_r     <= cfg_wdata[BASE_W-1:0];
        CFG_BASE_Z:     base_z_r     <= cfg_wdata[BASE_W-1:0];
        CFG_WARN_TICKS: warn_ticks_r <= cfg_wdata[TICKS_W-1:0];
        CFG_HOLD_TICKS: hold_ticks_r <= cfg_wdata[TICKS_W-1:0];
        default: ;
      endcase
    end
  end

  // The squared thresholds follow their registers in the next cycle.
  always_ff @(posedge clk) begin
    sev_sq_r <= TSQW'(sev_thr_r) * TSQW'(sev_thr_r);
    mod_sq_r <= TSQW'(mod_thr_r) * TSQW'(mod_thr_r);
  end

  // Pipeline flow control.
  logic a_v_r, b_v_r, c_v_r, out_v_r;
  logic o_rdy, c_rdy, b_rdy;
  logic a_load, b_load, c_load, d_load;

  assign o_rdy    = !out_v_r || out_ready;
  assign c_rdy    = !c_v_r || o_rdy;
  assign b_rdy    = !b_v_r || c_rdy;
  assign in_ready = !a_v_r || b_rdy;
  assign a_load   = in_valid && in_ready;
  assign b_load   = a_v_r && b_rdy;
  assign c_load   = b_v_r && c_rdy;
  assign d_load   = c_v_r && o_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r   <= 1'b0;
      b_v_r   <= 1'b0;
      c_v_r   <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      a_v_r   <= a_load || (a_v_r && !b_load);
      b_v_r   <= b_load || (b_v_r && !c_load);
      c_v_r   <= c_load || (c_v_r && !d_load);
      out_v_r <= d_load || (out_v_r && !out_ready);
    end
  end

  // Input register.
  logic [REQ_W-1:0]              a_req_r;
  logic signed [ACCEL_WIDTH-1:0] a_x_r, a_y_r, a_z_r;
  logic                          a_btn_r;

  always_ff @(posedge clk) begin
    if (a_load) begin
      a_req_r <= in_req_type;
      a_x_r   <= in_accel_x;
      a_y_r   <= in_accel_y;
      a_z_r   <= in_accel_z;
      a_btn_r <= in_button_low;
    end
  end

  // Axis values, magnitudes and squares.
  logic signed [DW-1:0]  ax_w, ay_w, az_w;
  logic signed [SQW-1:0] sqx_w, sqy_w, sqz_w;
  logic [DW-1:0]         aax_w, aay_w, aaz_w;

  assign ax_w  = DW'(a_x_r);
  assign ay_w  = DW'(a_y_r);
  assign az_w  = DW'(a_z_r) - $signed({1'b0, (DW-1)'(one_g_r)});
  assign sqx_w = ax_w * ax_w;
  assign sqy_w = ay_w * ay_w;
  assign sqz_w = az_w * az_w;
  assign aax_w = ax_w[DW-1] ? DW'(-ax_w) : DW'(ax_w);
  assign aay_w = ay_w[DW-1] ? DW'(-ay_w) : DW'(ay_w);
  assign aaz_w = az_w[DW-1] ? DW'(-az_w) : DW'(az_w);

  logic [REQ_W-1:0] b_req_r;
  logic             b_btn_r;
  logic [SQW-1:0]   b_sqx_r, b_sqy_r, b_sqz_r;
  logic [DW-1:0]    b_ax_r, b_ay_r, b_az_r;
  logic             b_sx_r, b_sy_r, b_sz_r;

  always_ff @(posedge clk) begin
    if (b_load) begin
      b_req_r <= a_req_r;
      b_btn_r <= a_btn_r;
      b_sqx_r <= unsigned'(sqx_w);
      b_sqy_r <= unsigned'(sqy_w);
      b_sqz_r <= unsigned'(sqz_w);
      b_ax_r  <= aax_w;
      b_ay_r  <= aay_w;
      b_az_r  <= aaz_w;
      b_sx_r  <= ax_w[DW-1];
      b_sy_r  <= ay_w[DW-1];
      b_sz_r  <= az_w[DW-1];
    end
  end

  // Magnitude tests, grade and type.
  logic [M2W-1:0] m2_w;
  logic           mag_sev_w, mag_mod_w, zdom_w, z_over_g_w;
  logic           x_over_b_w, y_over_b_w, z_over_b_w;
  logic [CW-1:0]  bx5_w, by5_w, bz5_w;
  itype_t         type_w;
  sev_t           sev_w;

  assign m2_w       = M2W'(b_sqx_r) + M2W'(b_sqy_r) + M2W'(b_sqz_r);
  assign mag_sev_w  = m2_w > M2W'(sev_sq_r);
  assign mag_mod_w  = m2_w > M2W'(mod_sq_r);
  assign bx5_w      = CW'({base_x_r, 2'b00}) + CW'(base_x_r);
  assign by5_w      = CW'({base_y_r, 2'b00}) + CW'(base_y_r);
  assign bz5_w      = CW'({base_z_r, 2'b00}) + CW'(base_z_r);
  assign x_over_b_w = CW'(b_ax_r) > bx5_w;
  assign y_over_b_w = CW'(b_ay_r) > by5_w;
  assign z_over_b_w = CW'(b_az_r) > bz5_w;
  assign zdom_w     = (b_az_r > b_ax_r) && (b_az_r > b_ay_r);
  assign z_over_g_w = b_az_r > DW'(one_g_r);

  always_comb begin
    type_w = IMP_NONE;
    sev_w  = SEV_NONE;
    if (req_t'(b_req_r) == REQ_SAMPLE) begin
      if (b_ax_r > DW'(sev_thr_r) || b_ay_r > DW'(sev_thr_r) || b_az_r > DW'(sev_thr_r)) begin
        sev_w = SEV_MAJOR;
      end else if (b_ax_r > DW'(mod_thr_r) || b_ay_r > DW'(mod_thr_r) ||
                   b_az_r > DW'(mod_thr_r)) begin
        sev_w = SEV_MINOR;
      end
      priority if (mag_sev_w && b_sz_r && z_over_g_w && zdom_w) begin
        type_w = IMP_FALL;
      end else if (mag_mod_w && x_over_b_w && y_over_b_w && z_over_b_w) begin
        type_w = IMP_COLLAPSE;
      end else if (mag_sev_w && !b_sz_r && z_over_g_w && zdom_w) begin
        type_w = IMP_LANDING;
      end else if (mag_mod_w && !b_sx_r && x_over_b_w) begin
        type_w = IMP_FRONT;
      end else if (mag_mod_w && b_sx_r && x_over_b_w) begin
        type_w = IMP_REAR;
      end else if (mag_mod_w && !b_sy_r && y_over_b_w) begin
        type_w = IMP_RIGHT;
      end else if (mag_mod_w && b_sy_r && y_over_b_w) begin
        type_w = IMP_LEFT;
      end else if (mag_mod_w) begin
        type_w = IMP_BLUNT;
      end else begin
        type_w = IMP_NONE;
      end
    end
  end

  logic [REQ_W-1:0] c_req_r;
  logic             c_btn_r;
  logic             c_mod_r;
  itype_t           c_type_r;
  sev_t             c_sev_r;

  always_ff @(posedge clk) begin
    if (c_load) begin
      c_req_r  <= b_req_r;
      c_btn_r  <= b_btn_r;
      c_mod_r  <= mag_mod_w;
      c_type_r <= type_w;
      c_sev_r  <= sev_w;
    end
  end

  // Alarm state. It changes only when a result enters the output register,
  // so the level outputs can be taken straight from it.
  logic [COUNT_WIDTH-1:0] minor_cnt_r, minor_cnt_nxt;
  logic                   cd_active_r, cd_active_nxt;
  logic [TIMER_WIDTH-1:0] cd_left_r, cd_left_nxt;
  logic                   hold_active_r, hold_active_nxt;
  logic [TIMER_WIDTH-1:0] hold_left_r, hold_left_nxt;
  logic                   blink_r, blink_nxt;
  logic                   warn_r, warn_nxt;
  logic                   doctor_r, doctor_nxt;
  logic                   started_w, canc_w, clr_w;

  always_comb begin
    minor_cnt_nxt   = minor_cnt_r;
    cd_active_nxt   = cd_active_r;
    cd_left_nxt     = cd_left_r;
    hold_active_nxt = hold_active_r;
    hold_left_nxt   = hold_left_r;
    blink_nxt       = blink_r;
    warn_nxt        = warn_r;
    doctor_nxt      = doctor_r;
    started_w       = 1'b0;
    canc_w          = 1'b0;
    clr_w           = 1'b0;
    unique case (c_req_r)
      REQ_SAMPLE: begin
        if (c_sev_r == SEV_MAJOR) begin
          if (!cd_active_r) begin
            cd_active_nxt = 1'b1;
            cd_left_nxt   = TIMER_WIDTH'(warn_ticks_r);
            started_w     = 1'b1;
          end
          blink_nxt = 1'b1;
        end else if (c_sev_r == SEV_MINOR && minor_cnt_r != '1) begin
          minor_cnt_nxt = minor_cnt_r + 1'b1;
        end
        if (minor_cnt_nxt >= COUNT_WIDTH'(MULTI_IMPACT_LIMIT) && c_mod_r) begin
          doctor_nxt = 1'b1;
        end
      end
      REQ_TICK: begin
        if (cd_active_r) begin
          if (cd_left_r <= TIMER_WIDTH'(1)) begin
            cd_active_nxt = 1'b0;
            cd_left_nxt   = '0;
            blink_nxt     = 1'b0;
            warn_nxt      = 1'b1;
          end else begin
            cd_left_nxt = cd_left_r - 1'b1;
          end
        end
        if (hold_active_r) begin
          if (hold_left_r <= TIMER_WIDTH'(1)) begin
            hold_active_nxt = 1'b0;
            hold_left_nxt   = '0;
            if (c_btn_r) begin
              minor_cnt_nxt = '0;
              doctor_nxt    = 1'b0;
              clr_w         = 1'b1;
            end
          end else begin
            hold_left_nxt = hold_left_r - 1'b1;
          end
        end
      end
      REQ_BUTTON: begin
        if (cd_active_r) begin
          cd_active_nxt = 1'b0;
          cd_left_nxt   = '0;
          blink_nxt     = 1'b0;
          canc_w        = 1'b1;
        end
        if (!hold_active_r) begin
          hold_active_nxt = 1'b1;
          hold_left_nxt   = TIMER_WIDTH'(hold_ticks_r);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      minor_cnt_r   <= '0;
      cd_active_r   <= 1'b0;
      cd_left_r     <= '0;
      hold_active_r <= 1'b0;
      hold_left_r   <= '0;
      blink_r       <= 1'b0;
      warn_r        <= 1'b0;
      doctor_r      <= 1'b0;
    end else if (d_load) begin
      minor_cnt_r   <= minor_cnt_nxt;
      cd_active_r   <= cd_active_nxt;
      cd_left_r     <= cd_left_nxt;
      hold_active_r <= hold_active_nxt;
      hold_left_r   <= hold_left_nxt;
      blink_r       <= blink_nxt;
      warn_r        <= warn_nxt;
      doctor_r      <= doctor_nxt;
    end
  end

  // Result register.
  itype_t out_type_r;
  sev_t   out_sev_r;
  logic   out_started_r, out_canc_r, out_clr_r;

  always_ff @(posedge clk) begin
    if (d_load) begin
      out_type_r    <= c_type_r;
      out_sev_r     <= c_sev_r;
      out_started_r <= started_w;
      out_canc_r    <= canc_w;
      out_clr_r     <= clr_w;
    end
  end

  assign out_valid          = out_v_r;
  assign out_hit_kind       = out_type_r;
  assign out_severity       = out_sev_r;
  assign out_major_started  = out_started_r;
  assign out_cancelled      = out_canc_r;
  assign out_cleared        = out_clr_r;
  assign out_warning_led_on = warn_r;
  assign out_blink_on       = blink_r;
  assign out_doctor_led_on  = doctor_r;
  assign out_impact_total   = minor_cnt_r;

endmodule

`default_nettype wire

### sv/impc_checker.sv
`default_nettype none

module impc_checker #(
  parameter int COUNT_WIDTH = 8
) (
  input wire                         clk,
  input wire                         rst_n,
  input wire                         out_valid,
  input wire                         out_ready,
  input wire [impc_pkg::TYPE_W-1:0]  out_hit_kind,
  input wire [impc_pkg::SEV_W-1:0]   out_severity,
  input wire                         out_major_started,
  input wire                         out_warning_led_on,
  input wire                         out_blink_on,
  input wire                         out_doctor_led_on,
  input wire                         out_cancelled,
  input wire                         out_cleared,
  input wire [COUNT_WIDTH-1:0]       out_impact_total
);
  import impc_pkg::*;

  // A stalled result beat keeps its whole payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_hit_kind) &&
      $stable(out_severity) && $stable(out_major_started) &&
      $stable(out_warning_led_on) && $stable(out_blink_on) &&
      $stable(out_doctor_led_on) && $stable(out_cancelled) &&
      $stable(out_cleared) && $stable(out_impact_total))
    else $error("result beat changed while stalled");

  a_start_major: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_major_started |-> out_severity == SEV_MAJOR && out_blink_on)
    else $error("countdown start without a major blinking sample");

  a_cancel: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_cancelled |-> !out_blink_on && out_severity == SEV_NONE &&
      !out_major_started)
    else $error("cancel beat left blinking on or carried a grade");

  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_cleared |-> out_impact_total == '0 && !out_doctor_led_on &&
      out_hit_kind == IMP_NONE)
    else $error("clear beat kept the impact count or doctor LED");

  a_warn_latch: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> !$fell(out_warning_led_on))
    else $error("warning LED dropped without reset");

endmodule

bind impact_classifier impc_checker #(.COUNT_WIDTH(COUNT_WIDTH)) u_impc_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_valid          (out_valid),
  .out_ready          (out_ready),
  .out_hit_kind       (out_hit_kind),
  .out_severity       (out_severity),
  .out_major_started  (out_major_started),
  .out_warning_led_on (out_warning_led_on),
  .out_blink_on       (out_blink_on),
  .out_doctor_led_on  (out_doctor_led_on),
  .out_cancelled      (out_cancelled),
  .out_cleared        (out_cleared),
  .out_impact_total   (out_impact_total)
);

`default_nettype wire

### verif/tb_top.sv
module tb_top;
  import impc_pkg::*;

  localparam int ACCEL_W = 13;
  localparam int TOTAL_W = 8;
  localparam int BASE_FACTOR = 5;
  localparam int DRAIN_CYCLES = 10;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int PRESSURE_CYCLES = 300;
  localparam int MAX_REPORTS = 60;
  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

  typedef enum int {SET_DEFAULT, SET_FLOOR, SET_CEILING, SET_RANDOM} settings_t;

  typedef struct {
    itype_t             itype;
    sev_t               sev;
    logic               started;
    logic               warn;
    logic               blink;
    logic               doctor;
    logic               canc;
    logic               clr;
    logic [TOTAL_W-1:0] total;
  } grade_t;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      in_valid = 1'b0;
  wire                       in_ready;
  logic [REQ_W-1:0]          in_req_type = '0;
  logic signed [ACCEL_W-1:0] in_accel_x = '0;
  logic signed [ACCEL_W-1:0] in_accel_y = '0;
  logic signed [ACCEL_W-1:0] in_accel_z = '0;
  logic                      in_button_low = 1'b0;
  wire                       out_valid;
  logic                      out_ready = 1'b0;
  wire [TYPE_W-1:0]          out_hit_kind;
  wire [SEV_W-1:0]           out_severity;
  wire                       out_major_started;
  wire                       out_warning_led_on;
  wire                       out_blink_on;
  wire                       out_doctor_led_on;
  wire                       out_cancelled;
  wire                       out_cleared;
  wire [TOTAL_W-1:0]         out_impact_total;
  logic                      cfg_valid = 1'b0;
  wire                       cfg_ready;
  logic [CFG_IDX_W-1:0]      cfg_index = '0;
  logic [CFG_DATA_W-1:0]     cfg_wdata = '0;

  // Shadow copy of the registers and the classifier state.
  logic [THRESH_W-1:0] sev_thr;
  logic [THRESH_W-1:0] mod_thr;
  logic [ONE_G_W-1:0]  one_g;
  logic [BASE_W-1:0]   base_x;
  logic [BASE_W-1:0]   base_y;
  logic [BASE_W-1:0]   base_z;
  logic [TICKS_W-1:0]  warn_ticks;
  logic [TICKS_W-1:0]  hold_ticks;
  logic [TOTAL_W-1:0]  impacts;
  logic                cd_on;
  logic [TICKS_W-1:0]  cd_left;
  logic                hold_on;
  logic [TICKS_W-1:0]  hold_left;
  logic                blink_st;
  logic                warn_st;
  logic                doctor_st;

  grade_t grades_due[$];

  int sender_idle_pct = 0;
  int receiver_stall_pct = 0;
  bit hold_off_start = 1'b0;
  int hold_cnt = 0;
  int quiet_cycles = 0;
  int beats_sent = 0;
  int results_checked = 0;
  int reg_writes = 0;
  int errors = 0;
  int majors = 0;
  int minors = 0;
  int cancels = 0;
  int clears = 0;

  impact_classifier dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_req_type        (in_req_type),
    .in_accel_x         (in_accel_x),
    .in_accel_y         (in_accel_y),
    .in_accel_z         (in_accel_z),
    .in_button_low      (in_button_low),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_hit_kind       (out_hit_kind),
    .out_severity       (out_severity),
    .out_major_started  (out_major_started),
    .out_warning_led_on (out_warning_led_on),
    .out_blink_on       (out_blink_on),
    .out_doctor_led_on  (out_doctor_led_on),
    .out_cancelled      (out_cancelled),
    .out_cleared        (out_cleared),
    .out_impact_total   (out_impact_total),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void apply_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
    case (idx)
      CFG_SEV_THR:    sev_thr = data[THRESH_W-1:0];
      CFG_MOD_THR:    mod_thr = data[THRESH_W-1:0];
      CFG_ONE_G:      one_g = data[ONE_G_W-1:0];
      CFG_BASE_X:     base_x = data[BASE_W-1:0];
      CFG_BASE_Y:     base_y = data[BASE_W-1:0];
      CFG_BASE_Z:     base_z = data[BASE_W-1:0];
      CFG_WARN_TICKS: warn_ticks = data[TICKS_W-1:0];
      CFG_HOLD_TICKS: hold_ticks = data[TICKS_W-1:0];
      default: ;
    endcase
  endfunction

  function automatic grade_t grade_beat(logic [REQ_W-1:0] req, logic signed [ACCEL_W-1:0] x,
                                        logic signed [ACCEL_W-1:0] y,
                                        logic signed [ACCEL_W-1:0] z, logic btn);
    grade_t v;
    int ax, ay, az, aax, aay, aaz, st, mt, g, bx, by, bz;
    longint m2;
    logic mag_sev, mag_mod, zdom;
    v.itype = IMP_NONE;
    v.sev = SEV_NONE;
    v.started = 1'b0;
    v.canc = 1'b0;
    v.clr = 1'b0;
    case (req)
      REQ_SAMPLE: begin
        ax = x;
        ay = y;
        az = int'(z) - int'(one_g);
        aax = (ax < 0) ? -ax : ax;
        aay = (ay < 0) ? -ay : ay;
        aaz = (az < 0) ? -az : az;
        st = sev_thr;
        mt = mod_thr;
        g = one_g;
        bx = BASE_FACTOR * int'(base_x);
        by = BASE_FACTOR * int'(base_y);
        bz = BASE_FACTOR * int'(base_z);
        m2 = longint'(ax) * ax + longint'(ay) * ay + longint'(az) * az;
        mag_sev = m2 > longint'(st) * st;
        mag_mod = m2 > longint'(mt) * mt;
        zdom = (aaz > aax) && (aaz > aay);
        if (aax > st || aay > st || aaz > st) begin
          v.sev = SEV_MAJOR;
          if (!cd_on) begin
            cd_on = 1'b1;
            cd_left = warn_ticks;
            v.started = 1'b1;
          end
          blink_st = 1'b1;
        end else if (aax > mt || aay > mt || aaz > mt) begin
          v.sev = SEV_MINOR;
          if (impacts != '1) impacts = impacts + 1'b1;
        end
        if (mag_sev && az < -g && zdom) v.itype = IMP_FALL;
        else if (mag_mod && aax > bx && aay > by && aaz > bz) v.itype = IMP_COLLAPSE;
        else if (mag_sev && az > g && zdom) v.itype = IMP_LANDING;
        else if (mag_mod && ax > bx) v.itype = IMP_FRONT;
        else if (mag_mod && ax < -bx) v.itype = IMP_REAR;
        else if (mag_mod && ay > by) v.itype = IMP_RIGHT;
        else if (mag_mod && ay < -by) v.itype = IMP_LEFT;
        else if (mag_mod) v.itype = IMP_BLUNT;
        if (impacts >= MULTI_IMPACT_LIMIT && mag_mod) doctor_st = 1'b1;
      end
      REQ_TICK: begin
        if (cd_on) begin
          if (cd_left <= 1) begin
            cd_on = 1'b0;
            cd_left = '0;
            blink_st = 1'b0;
            warn_st = 1'b1;
          end else begin
            cd_left = cd_left - 1'b1;
          end
        end
        if (hold_on) begin
          if (hold_left <= 1) begin
            hold_on = 1'b0;
            hold_left = '0;
            if (btn) begin
              impacts = '0;
              doctor_st = 1'b0;
              v.clr = 1'b1;
            end
          end else begin
            hold_left = hold_left - 1'b1;
          end
        end
      end
      REQ_BUTTON: begin
        if (cd_on) begin
          cd_on = 1'b0;
          cd_left = '0;
          blink_st = 1'b0;
          v.canc = 1'b1;
        end
        if (!hold_on) begin
          hold_on = 1'b1;
          hold_left = hold_ticks;
        end
      end
      default: ;
    endcase
    v.warn = warn_st;
    v.blink = blink_st;
    v.doctor = doctor_st;
    v.total = impacts;
    return v;
  endfunction

  task automatic send_beat(logic [REQ_W-1:0] req, logic signed [ACCEL_W-1:0] x,
                           logic signed [ACCEL_W-1:0] y, logic signed [ACCEL_W-1:0] z,
                           logic btn);
    grade_t g;
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_req_type <= req;
    in_accel_x <= x;
    in_accel_y <= y;
    in_accel_z <= z;
    in_button_low <= btn;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    g = grade_beat(req, x, y, z, btn);
    grades_due.push_back(g);
    beats_sent++;
    if (g.sev == SEV_MAJOR) majors++;
    if (g.sev == SEV_MINOR) minors++;
    if (g.canc) cancels++;
    if (g.clr) clears++;
    @(negedge clk);
  endtask

  function automatic logic signed [ACCEL_W-1:0] rand_raw();
    return ACCEL_W'($urandom());
  endfunction

  task automatic send_sample(int x, int y, int z);
    send_beat(REQ_SAMPLE, ACCEL_W'(x), ACCEL_W'(y), ACCEL_W'(z), 1'($urandom_range(1)));
  endtask

  task automatic send_tick(logic btn);
    send_beat(REQ_TICK, rand_raw(), rand_raw(), rand_raw(), btn);
  endtask

  task automatic send_button();
    send_beat(REQ_BUTTON, rand_raw(), rand_raw(), rand_raw(), 1'($urandom_range(1)));
  endtask

  task automatic wait_for_idle();
    in_valid <= 1'b0;
    while (grades_due.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    apply_reg(idx, data);
    reg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic load_settings(logic [CFG_DATA_W-1:0] s, logic [CFG_DATA_W-1:0] m,
                               logic [CFG_DATA_W-1:0] g, logic [CFG_DATA_W-1:0] bx,
                               logic [CFG_DATA_W-1:0] by, logic [CFG_DATA_W-1:0] bz,
                               logic [CFG_DATA_W-1:0] wt, logic [CFG_DATA_W-1:0] ht);
    wait_for_idle();
    write_reg(CFG_SEV_THR, s);
    write_reg(CFG_MOD_THR, m);
    write_reg(CFG_ONE_G, g);
    write_reg(CFG_BASE_X, bx);
    write_reg(CFG_BASE_Y, by);
    write_reg(CFG_BASE_Z, bz);
    write_reg(CFG_WARN_TICKS, wt);
    write_reg(CFG_HOLD_TICKS, ht);
  endtask

  function automatic logic [CFG_DATA_W-1:0] rand_base();
    return ($urandom_range(7) == 0) ? CFG_DATA_W'(4096) : CFG_DATA_W'($urandom_range(0, 300));
  endfunction

  task automatic pick_settings(settings_t which);
    logic [CFG_DATA_W-1:0] s, m;
    case (which)
      SET_DEFAULT: load_settings(CFG_DATA_W'(SEV_THR_RST), CFG_DATA_W'(MOD_THR_RST),
                                 CFG_DATA_W'(ONE_G_RST), CFG_DATA_W'(BASE_RST),
                                 CFG_DATA_W'(BASE_RST), CFG_DATA_W'(BASE_RST),
                                 WARN_TICKS_RST, HOLD_TICKS_RST);
      SET_FLOOR:   load_settings('0, '0, '0, '0, '0, '0, '0, '0);
      SET_CEILING: load_settings('1, '1, '1, '1, '1, '1, '1, '1);
      default: begin
        m = CFG_DATA_W'($urandom_range(100, 3000));
        s = ($urandom_range(7) == 0) ? CFG_DATA_W'($urandom_range(0, m)) :
                                       CFG_DATA_W'(m + $urandom_range(0, 3000));
        if ($urandom_range(9) == 0) s = CFG_DATA_W'($urandom());
        load_settings(s, m, CFG_DATA_W'($urandom_range(0, 600)), rand_base(), rand_base(),
                      rand_base(), CFG_DATA_W'($urandom_range(0, 40)),
                      CFG_DATA_W'($urandom_range(0, 40)));
      end
    endcase
  endtask

  // Axis values cluster around zero, both thresholds and the full range.
  function automatic logic signed [ACCEL_W-1:0] rand_axis();
    int v;
    int t;
    case ($urandom_range(0, 4))
      0: v = $urandom();
      1: v = int'($urandom_range(0, 2 * mod_thr)) - int'(mod_thr);
      2: begin
        t = $urandom_range(1) ? int'(sev_thr) : int'(mod_thr);
        v = t + int'($urandom_range(0, 4)) - 2;
        if ($urandom_range(1)) v = -v;
      end
      3: v = 0;
      default: v = int'($urandom_range(0, 600)) - 300;
    endcase
    return ACCEL_W'(v);
  endfunction

  task automatic send_random_beat(output bit counted);
    int pick;
    logic signed [ACCEL_W-1:0] z;
    pick = $urandom_range(99);
    counted = 1'b1;
    if (pick < 52) begin
      z = rand_axis();
      if ($urandom_range(1)) z = z + ACCEL_W'(one_g);
      send_beat(REQ_SAMPLE, rand_axis(), rand_axis(), z, 1'($urandom_range(1)));
    end else if (pick < 80) begin
      send_tick(1'($urandom_range(1)));
    end else if (pick < 93) begin
      send_button();
    end else begin
      send_beat(REQ_UNUSED, rand_raw(), rand_raw(), rand_raw(), 1'($urandom_range(1)));
      counted = 1'b0;
    end
  endtask

  task automatic run_random(int n, int idle_pct, int stall_pct);
    int done;
    bit counted;
    sender_idle_pct = idle_pct;
    receiver_stall_pct = stall_pct;
    done = 0;
    while (done < n) begin
      send_random_beat(counted);
      if (counted) done++;
    end
  endtask

  task automatic set_ticks(logic [CFG_DATA_W-1:0] wt, logic [CFG_DATA_W-1:0] ht);
    wait_for_idle();
    write_reg(CFG_WARN_TICKS, wt);
    write_reg(CFG_HOLD_TICKS, ht);
  endtask

  task automatic test_impact_types();
    pick_settings(SET_DEFAULT);
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    send_sample(0, 0, 256);
    send_sample(0, 0, -4096);
    send_sample(0, 0, 4095);
    send_sample(2000, 2000, 2000);
    send_sample(2000, 0, 256);
    send_sample(-2000, 0, 256);
    send_sample(0, 2000, 256);
    send_sample(0, -2000, 256);
    send_sample(0, 0, 2256);
    send_sample(-4096, -4096, -4096);
    send_sample(4095, 4095, 4095);
  endtask

  task automatic test_cancel_and_hold();
    set_ticks(5, 2);
    send_button();
    send_button();
    send_tick(1'b1);
    send_tick(1'b1);
    send_button();
    send_tick(1'b0);
    send_tick(1'b0);
  endtask

  task automatic test_unknown_request();
    send_beat(REQ_UNUSED, rand_raw(), rand_raw(), rand_raw(), 1'b1);
    send_beat(REQ_UNUSED, rand_raw(), rand_raw(), rand_raw(), 1'b0);
  endtask

  // A countdown loaded with zero must expire on its first tick, as one does.
  task automatic test_warning_expiry();
    set_ticks(0, 0);
    send_sample(4095, 0, 256);
    send_tick(1'b0);
    send_button();
    send_tick(1'b1);
    set_ticks(2, 1);
    send_sample(0, -4096, 256);
    send_sample(4095, 0, 256);
    send_tick(1'b0);
    send_tick(1'b0);
    send_tick(1'b1);
  endtask

  task automatic test_count_saturation();
    int axis, hit, k;
    int v[3];
    pick_settings(SET_DEFAULT);
    sender_idle_pct = 8;
    receiver_stall_pct = 8;
    for (k = 0; k < 270; k++) begin
      axis = $urandom_range(0, 2);
      for (int a = 0; a < 3; a++) v[a] = int'($urandom_range(0, 2 * mod_thr)) - int'(mod_thr);
      hit = int'($urandom_range(mod_thr + 1, sev_thr));
      v[axis] = $urandom_range(1) ? hit : -hit;
      send_sample(v[0], v[1], v[2] + int'(one_g));
    end
    send_button();
    repeat (3) send_tick(1'b0);
  endtask

  task automatic test_backpressure();
    pick_settings(SET_RANDOM);
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    @(posedge clk);
    hold_off_start = 1'b1;
    @(negedge clk);
    run_random(40, 0, 0);
  endtask

  task automatic test_random_traffic();
    int idle_mix[4];
    int stall_mix[4];
    settings_t plan[8];
    idle_mix = '{0, 82, 0, 8};
    stall_mix = '{0, 0, 82, 8};
    plan = '{SET_RANDOM, SET_FLOOR, SET_RANDOM, SET_CEILING,
             SET_DEFAULT, SET_RANDOM, SET_RANDOM, SET_RANDOM};
    for (int p = 0; p < 8; p++) begin
      pick_settings(plan[p]);
      run_random(200, idle_mix[p / 2], stall_mix[p / 2]);
    end
  endtask

  task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
    errors++;
    if (errors <= MAX_REPORTS)
      $display("Mismatch on result %0d: %s is %0h, expected %0h",
               results_checked, what, got, want);
  endtask

  always @(negedge clk) begin
    if (hold_off_start) begin
      hold_cnt = PRESSURE_CYCLES;
      hold_off_start = 1'b0;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  always @(posedge clk) begin : result_check
    grade_t want;
    if (rst_n && out_valid && out_ready) begin
      if (grades_due.size() == 0) begin
        report_mismatch("beat with nothing outstanding", '0, '0);
      end else begin
        want = grades_due.pop_front();
        if (out_hit_kind !== want.itype)
          report_mismatch("hit_kind", 16'(out_hit_kind), 16'(want.itype));
        if (out_severity !== want.sev)
          report_mismatch("severity", 16'(out_severity), 16'(want.sev));
        if (out_major_started !== want.started)
          report_mismatch("major_started", 16'(out_major_started), 16'(want.started));
        if (out_warning_led_on !== want.warn)
          report_mismatch("warning_led_on", 16'(out_warning_led_on), 16'(want.warn));
        if (out_blink_on !== want.blink)
          report_mismatch("blink_on", 16'(out_blink_on), 16'(want.blink));
        if (out_doctor_led_on !== want.doctor)
          report_mismatch("doctor_led_on", 16'(out_doctor_led_on), 16'(want.doctor));
        if (out_cancelled !== want.canc)
          report_mismatch("cancelled", 16'(out_cancelled), 16'(want.canc));
        if (out_cleared !== want.clr)
          report_mismatch("cleared", 16'(out_cleared), 16'(want.clr));
        if (out_impact_total !== want.total)
          report_mismatch("impact_total", 16'(out_impact_total), 16'(want.total));
      end
      results_checked++;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog: no beat moved for %0d cycles, %0d results outstanding",
               quiet_cycles, grades_due.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    sev_thr = SEV_THR_RST;
    mod_thr = MOD_THR_RST;
    one_g = ONE_G_RST;
    base_x = BASE_RST;
    base_y = BASE_RST;
    base_z = BASE_RST;
    warn_ticks = WARN_TICKS_RST;
    hold_ticks = HOLD_TICKS_RST;
    impacts = '0;
    cd_on = 1'b0;
    cd_left = '0;
    hold_on = 1'b0;
    hold_left = '0;
    blink_st = 1'b0;
    warn_st = 1'b0;
    doctor_st = 1'b0;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_impact_types();
    test_cancel_and_hold();
    test_unknown_request();
    test_warning_expiry();
    test_count_saturation();
    test_backpressure();
    test_random_traffic();
    wait_for_idle();
    $display("Covered %0d input beats and %0d checked results over %0d register writes.",
             beats_sent, results_checked, reg_writes);
    $display("Graded %0d major and %0d minor samples; %0d cancels and %0d hold clears seen.",
             majors, minors, cancels, clears);
    if (errors == 0 && grades_due.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches, %0d results never arrived", errors, grades_due.size());
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

### impact_classifier.f
sv/impc_pkg.sv
sv/impact_classifier.sv
sv/impc_checker.sv
verif/tb_top.sv
